// ===== rtl/rec_pkg.sv =====
// types, constants and helpers shared by the read extent coalescer modules
`timescale 1ns / 1ps

package rec_pkg;

	// field widths
	localparam int GROUP_W  = 4;
	localparam int OFFSET_W = 40;
	localparam int LENGTH_W = 24;
	localparam int OUTLEN_W = 32;
	localparam int COUNT_W  = 16;

	// default number of groups
	localparam int REC_GROUPS = 16;

	// result queue depth and derived widths
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	// packed bus widths, rounded up to whole bytes
	localparam int IN_DATA_W  = ((GROUP_W + OFFSET_W + LENGTH_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((GROUP_W + OFFSET_W + OUTLEN_W + COUNT_W + 7) / 8) * 8;

	// one incoming read request
	typedef struct packed {
		logic [GROUP_W-1:0]  group;
		logic [OFFSET_W-1:0] offset;
		logic [LENGTH_W-1:0] length;
		logic                batch_last;
	} req_t;

	// one emitted extent
	typedef struct packed {
		logic [GROUP_W-1:0]  group;
		logic [OFFSET_W-1:0] offset;
		logic [OUTLEN_W-1:0] length;
		logic                group_end;
		logic                batch_end;
		logic [COUNT_W-1:0]  count;
	} ext_t;

	// which of the two possible extents a request produces
	typedef struct packed {
		logic emit_a;
		logic emit_b;
	} push_t;

	// saturating increment of the extent count
	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
		logic [COUNT_W-1:0] r;
		if (c == {COUNT_W{1'b1}}) begin
			r = c;
		end else begin
			r = c + COUNT_W'(1);
		end
		return r;
	endfunction

endpackage

// ===== rtl/rec_merge.sv =====
// pending extent register with contiguity check, merge and flush logic
`timescale 1ns / 1ps

module rec_merge import rec_pkg::*; #(
	parameter int GROUPS = REC_GROUPS
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	input  req_t  req,
	output push_t push,
	output ext_t  res_a,
	output ext_t  res_b
);

	logic                pend_valid_q;
	logic [GROUP_W-1:0]  pend_group_q;
	logic [OFFSET_W-1:0] pend_offset_q;
	logic [OUTLEN_W-1:0] pend_length_q;
	logic [COUNT_W-1:0]  count_q;

	logic [GROUP_W-1:0]  grp;
	logic [OFFSET_W:0]   end_sum;
	logic [OUTLEN_W:0]   len_sum;
	logic                same;
	logic                contig;
	logic                fits;
	logic                merge;
	logic [COUNT_W-1:0]  cnt_a;
	logic [COUNT_W-1:0]  cnt_after_a;
	logic [COUNT_W-1:0]  cnt_b;
	logic [GROUP_W-1:0]  new_group;
	logic [OFFSET_W-1:0] new_offset;
	logic [OUTLEN_W-1:0] new_length;

	// fold the group number into range, a few narrow subtract steps
	always_comb begin
		logic [8:0] g;
		g = {5'b0, req.group};
		for (int i = 0; i < 8; i++) begin
			if (g >= 9'(GROUPS)) begin
				g = g - 9'(GROUPS);
			end
		end
		grp = g[GROUP_W-1:0];
	end

	// end of pending extent and merged length, neither wraps
	assign end_sum = {1'b0, pend_offset_q} + (OFFSET_W+1)'(pend_length_q);
	assign len_sum = {1'b0, pend_length_q} + (OUTLEN_W+1)'(req.length);
	assign same    = (grp == pend_group_q);
	assign contig  = (end_sum == {1'b0, req.offset});
	assign fits    = ~len_sum[OUTLEN_W];
	assign merge   = pend_valid_q & same & contig & fits;

	// which extents go out for this request
	assign push.emit_a = req_valid & pend_valid_q & ~merge;
	assign push.emit_b = req_valid & req.batch_last;

	// running extent counts
	assign cnt_a       = sat_inc(count_q);
	assign cnt_after_a = push.emit_a ? cnt_a : count_q;
	assign cnt_b       = sat_inc(cnt_after_a);

	// pending extent after this request
	always_comb begin
		if (merge) begin
			new_group  = pend_group_q;
			new_offset = pend_offset_q;
			new_length = len_sum[OUTLEN_W-1:0];
		end else begin
			new_group  = grp;
			new_offset = req.offset;
			new_length = OUTLEN_W'(req.length);
		end
	end

	// the broken-off extent and the batch flush
	always_comb begin
		res_a.group     = pend_group_q;
		res_a.offset    = pend_offset_q;
		res_a.length    = pend_length_q;
		res_a.group_end = ~same;
		res_a.batch_end = 1'b0;
		res_a.count     = cnt_a;
		res_b.group     = new_group;
		res_b.offset    = new_offset;
		res_b.length    = new_length;
		res_b.group_end = 1'b1;
		res_b.batch_end = 1'b1;
		res_b.count     = cnt_b;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			count_q      <= '0;
			pend_group_q <= '0;
		end else if (req_valid) begin
			pend_valid_q <= ~req.batch_last;
			count_q      <= req.batch_last ? '0 : cnt_after_a;
			pend_group_q <= new_group;
		end
	end

	// pending extent payload
	always_ff @(posedge clk) begin
		if (req_valid) begin
			pend_offset_q <= new_offset;
			pend_length_q <= new_length;
		end
	end

endmodule

// ===== rtl/rec_outq.sv =====
// small result queue taking up to two extents a cycle and giving one whenever out_ready is high
`timescale 1ns / 1ps

module rec_outq import rec_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	input  ext_t  res_a,
	input  ext_t  res_b,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output ext_t  out_word
);

	ext_t                entry_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q;
	logic [OQ_PTR_W-1:0] rd_ptr_q;
	logic [OQ_CNT_W-1:0] count_q;

	logic                pop;
	logic [OQ_CNT_W-1:0] push_n;
	ext_t                first_word;
	logic [OQ_PTR_W-1:0] wr_ptr_next;

	// occupancy and handshake
	assign push_n      = OQ_CNT_W'(push.emit_a) + OQ_CNT_W'(push.emit_b);
	assign pop         = out_valid & out_ready;
	assign out_valid   = (count_q != '0);
	assign out_word    = entry_q[rd_ptr_q];
	assign room        = (count_q <= OQ_CNT_W'(OQ_DEPTH - 2));
	assign first_word  = push.emit_a ? res_a : res_b;
	assign wr_ptr_next = wr_ptr_q + OQ_PTR_W'(1);

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(1);
			end
			count_q <= count_q + push_n - OQ_CNT_W'(pop);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push_n != '0) begin
			entry_q[wr_ptr_q] <= first_word;
		end
		if (push.emit_a && push.emit_b) begin
			entry_q[wr_ptr_next] <= res_b;
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= OQ_CNT_W'(OQ_DEPTH))
		else $error("result queue over capacity");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != '0) |-> (count_q <= OQ_CNT_W'(OQ_DEPTH - 2)))
		else $error("extent pushed without room");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push_n == '0) |=> (count_q == $past(count_q) - OQ_CNT_W'(1)))
		else $error("queue count wrong after pop");

	a_double_push: assert property (@(posedge clk) disable iff (!arst_n)
		(push.emit_a && push.emit_b) |=> (count_q >= OQ_CNT_W'(1)))
		else $error("double push lost");

endmodule

// ===== rtl/read_extent_coalescer.sv =====
// top level of the read extent coalescer
`timescale 1ns / 1ps

// Merges a stream of read requests into contiguous extents, one request a
// cycle while s_tready is high. A request is held in the input register, then
// the contiguity compare and length add run against the pending extent and the
// resulting extents enter a four-word result queue, whose registered entries
// are offered on m_tvalid. A request that breaks an extent and also ends the
// batch yields two words; the queue takes both in the same cycle and then
// drains one a cycle while m_tready is high, so the sustained rate is one
// request per cycle while each request yields at most one word and m_tready
// stays high, and follows the output side otherwise. s_tready drops only
// when the result queue has fewer than two free entries.

module read_extent_coalescer import rec_pkg::*; #(
	parameter int GROUPS = REC_GROUPS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // group, offset, length, zero fill
	input  logic                  s_tlast,  // batch_last
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // out_group, out_offset, out_length,
	                                        // extent_count, zero fill
	output logic                  m_tuser,  // group_end
	output logic                  m_tlast   // batch_end
);

	logic  valid_s1;
	req_t  req_s1;
	logic  room;
	logic  advance;
	push_t push;
	ext_t  res_a;
	ext_t  res_b;
	ext_t  out_word;

	// input register handshake
	assign advance  = valid_s1 & room;
	assign s_tready = ~valid_s1 | room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.group      <= s_tdata[GROUP_W-1:0];
			req_s1.offset     <= s_tdata[GROUP_W +: OFFSET_W];
			req_s1.length     <= s_tdata[GROUP_W+OFFSET_W +: LENGTH_W];
			req_s1.batch_last <= s_tlast;
		end
	end

	// merge against the pending extent
	rec_merge #(
		.GROUPS(GROUPS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(advance),
		.req      (req_s1),
		.push     (push),
		.res_a    (res_a),
		.res_b    (res_b)
	);

	// result queue
	rec_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.res_a    (res_a),
		.res_b    (res_b),
		.room     (room),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_word (out_word)
	);

	// output word packing
	assign m_tdata = OUT_DATA_W'({out_word.count, out_word.length,
		out_word.offset, out_word.group});
	assign m_tuser = out_word.group_end;
	assign m_tlast = out_word.batch_end;

endmodule

// ===== tb/read_extent_coalescer_test.sv =====
// self-checking testbench for the read extent coalescer
`timescale 1ns / 1ps

module read_extent_coalescer_test;
	import rec_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 4;
	// quiet cycles after the last due extent, past the input register and result queue
	localparam int DRAIN_CYCLES   = 8;
	// receiver hold-off, long enough to fill the result queue and stall input
	localparam int RX_HOLD_CYCLES = 120;
	localparam int RANDOM_ITEMS   = 350;
	localparam int HOLD_ITEMS     = 24;
	// a correct run stays far under the limit, even with two words each and the
	// receiver at its slowest pattern
	localparam int CYCLE_LIMIT    = 200000;
	localparam int PRINT_LIMIT    = 40;

	// result word field positions, lowest bit up
	localparam int O_OFF_LO = GROUP_W;
	localparam int O_LEN_LO = O_OFF_LO + OFFSET_W;
	localparam int O_CNT_LO = O_LEN_LO + OUTLEN_W;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;  // group, offset, length, zero fill
	logic                  s_tlast = 1'b0;  // batch_last
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;  // out_group, out_offset, out_length,
	                                 // extent_count, zero fill
	logic                  m_tuser;  // group_end
	logic                  m_tlast;  // batch_end

	read_extent_coalescer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// extents still owed by the block, oldest first
	ext_t extents_due[$];
	int   mismatch_count = 0;
	int   cycle_count = 0;
	bit   hold_req = 1'b0;
	bit   paced_sender = 1'b1;
	int   burst_left = 0;

	// coalescer image: pending extent and batch extent count
	logic                pend_valid;
	logic [GROUP_W-1:0]  pend_group;
	logic [OFFSET_W-1:0] pend_off;
	logic [OUTLEN_W-1:0] pend_len;
	logic [COUNT_W-1:0]  batch_extents;

	// extents produced by the latest request
	ext_t step_out [2];
	int   step_n;

	// directed requests; known extents typed in where obvious, -1 means predicted
	localparam int DIR_ROWS = 17;
	req_t dir_req [DIR_ROWS] = '{
		'{4'h0, 40'h0,          24'h1,      1'b1},  // lone request flushed
		'{4'hF, 40'hFFFFFFFFFF, 24'hFFFFFF, 1'b0},  // top offset, top length
		'{4'hF, 40'hFFFFFE,     24'h10,     1'b0},  // end past 40 bits must not wrap
		'{4'hF, 40'h100000E,    24'h20,     1'b0},  // contiguous, merges
		'{4'h3, 40'h100002E,    24'h5,      1'b0},  // contiguous but new group
		'{4'h3, 40'h1000033,    24'h0,      1'b0},  // zero length merges
		'{4'h3, 40'h1000033,    24'h7,      1'b1},  // merge then batch flush
		'{4'h9, 40'h1234,       24'h100,    1'b1},  // fresh batch, single flush
		'{4'h9, 40'h1334,       24'h1,      1'b0},  // contiguous yet nothing pending
		'{4'hA, 40'h1335,       24'h2,      1'b1},  // break and flush together
		'{4'h5, 40'h500,        24'h10,     1'b0},
		'{4'h5, 40'h400,        24'h100,    1'b0},  // same group, backwards
		'{4'h5, 40'h500,        24'h10,     1'b1},
		'{4'hA, 40'hAAAAAAAAAA, 24'hAAAAAA, 1'b0},
		'{4'h5, 40'h5555555555, 24'h555555, 1'b0},
		'{4'h5, 40'h5555AAAAAA, 24'h555555, 1'b0},
		'{4'hC, 40'h0,          24'hFFFFFF, 1'b1}
	};
	int dir_known [DIR_ROWS] = '{1, 0, 1, 0, 1, 0, 1, 1, 0, 2, 0, 1, 1, -1, -1, -1, -1};
	ext_t dir_want [9] = '{
		'{4'h0, 40'h0,          32'h1,        1'b1, 1'b1, 16'd1},
		'{4'hF, 40'hFFFFFFFFFF, 32'hFFFFFF,   1'b0, 1'b0, 16'd1},
		'{4'hF, 40'hFFFFFE,     32'h30,       1'b1, 1'b0, 16'd2},
		'{4'h3, 40'h100002E,    32'hC,        1'b1, 1'b1, 16'd3},
		'{4'h9, 40'h1234,       32'h100,      1'b1, 1'b1, 16'd1},
		'{4'h9, 40'h1334,       32'h1,        1'b1, 1'b0, 16'd1},
		'{4'hA, 40'h1335,       32'h2,        1'b1, 1'b1, 16'd2},
		'{4'h5, 40'h500,        32'h10,       1'b0, 1'b0, 16'd1},
		'{4'h5, 40'h400,        32'h110,      1'b1, 1'b1, 16'd2}
	};

	// random stream cursor: where a contiguous follow-up would start
	logic [GROUP_W-1:0]  cur_group = '0;
	logic [OFFSET_W-1:0] cur_end = '0;

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT) begin
			$display("mismatch at %0t: %s", $time, msg);
		end
		mismatch_count++;
	endtask

	// close the pending extent into the next output slot
	function automatic void close_extent(input logic gend, input logic bend);
		if (batch_extents != '1) begin
			batch_extents = batch_extents + COUNT_W'(1);
		end
		step_out[step_n].group     = pend_group;
		step_out[step_n].offset    = pend_off;
		step_out[step_n].length    = pend_len;
		step_out[step_n].group_end = gend;
		step_out[step_n].batch_end = bend;
		step_out[step_n].count     = batch_extents;
		step_n++;
	endfunction

	// advance the coalescer image by one request
	function automatic void coalesce_request(input req_t r);
		logic [GROUP_W-1:0]    grp;
		logic [OFFSET_W+1:0]   pend_end;
		logic [OUTLEN_W:0]     merged;
		logic                  same;
		logic                  contig;
		logic                  fits;
		step_n = 0;
		grp = GROUP_W'(int'(r.group) % REC_GROUPS);
		if (pend_valid) begin
			// end is compared at full width, so a run past the top never wraps
			pend_end = (OFFSET_W + 2)'(pend_off) + (OFFSET_W + 2)'(pend_len);
			merged   = (OUTLEN_W + 1)'(pend_len) + (OUTLEN_W + 1)'(r.length);
			same   = (grp == pend_group);
			contig = (pend_end == (OFFSET_W + 2)'(r.offset));
			fits   = (merged <= (OUTLEN_W + 1)'({OUTLEN_W{1'b1}}));
			if (same && contig && fits) begin
				pend_len = merged[OUTLEN_W-1:0];
			end else begin
				close_extent(!same, 1'b0);
				pend_group = grp;
				pend_off   = r.offset;
				pend_len   = OUTLEN_W'(r.length);
			end
		end else begin
			pend_valid = 1'b1;
			pend_group = grp;
			pend_off   = r.offset;
			pend_len   = OUTLEN_W'(r.length);
		end
		if (r.batch_last) begin
			close_extent(1'b1, 1'b1);
			pend_valid    = 1'b0;
			batch_extents = '0;
		end
	endfunction

	function automatic void expect_predicted(input req_t r);
		coalesce_request(r);
		for (int k = 0; k < step_n; k++) begin
			extents_due.push_back(step_out[k]);
		end
	endfunction

	// offer one request from a falling edge, return at the falling edge after acceptance
	task automatic offer_request(input req_t r);
		int gap;
		if (paced_sender) begin
			if (burst_left == 0) begin
				gap = $urandom_range(0, 6);
				burst_left = $urandom_range(1, 16);
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			burst_left--;
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_DATA_W'({r.length, r.offset, r.group});
		s_tlast  <= r.batch_last;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// sender goes quiet until every due extent has been taken
	task automatic wait_all_taken();
		s_tvalid <= 1'b0;
		wait (extents_due.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [LENGTH_W-1:0] pick_length();
		int d;
		d = $urandom_range(0, 19);
		case (d)
			0: return '0;
			1: return '1;
			2, 3, 4, 5: return LENGTH_W'($urandom);
			default: return LENGTH_W'($urandom_range(1, 4096));
		endcase
	endfunction

	function automatic logic [OFFSET_W-1:0] pick_offset();
		if ($urandom_range(0, 3) == 0) begin
			return '1 - OFFSET_W'($urandom_range(0, 65535));
		end
		return OFFSET_W'({$urandom, $urandom});
	endfunction

	// one well-formed batch: mostly contiguous runs, some breaks and group hops
	task automatic send_random_batch(input int n, inout int sent);
		req_t r;
		int   c;
		for (int k = 0; k < n; k++) begin
			c = $urandom_range(0, 99);
			r.group  = cur_group;
			r.offset = cur_end;
			if (c >= 55 && c < 70) begin
				r.group = GROUP_W'($urandom);
			end else if (c >= 70 && c < 85) begin
				r.offset = pick_offset();
			end else if (c >= 85) begin
				r.group  = GROUP_W'($urandom);
				r.offset = pick_offset();
			end
			r.length     = pick_length();
			r.batch_last = (k == n - 1);
			offer_request(r);
			expect_predicted(r);
			cur_group = r.group;
			cur_end   = r.offset + OFFSET_W'(r.length);
			sent++;
		end
	endtask

	// receiver: segments of steady, random half-rate or three-quarter-rate ready, with a long hold on request
	initial begin
		int seg;
		int mode;
		@(posedge arst_n);
		forever begin
			seg  = $urandom_range(1, 40);
			mode = $urandom_range(0, 2);
			repeat (seg) begin
				@(negedge clk);
				if (hold_req) begin
					m_tready <= 1'b0;
					repeat (RX_HOLD_CYCLES) @(negedge clk);
					hold_req = 1'b0;
				end
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// result checker: each taken word against the oldest due extent
	always @(posedge clk) begin
		ext_t got;
		ext_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.group     = m_tdata[GROUP_W-1:0];
			got.offset    = m_tdata[O_OFF_LO +: OFFSET_W];
			got.length    = m_tdata[O_LEN_LO +: OUTLEN_W];
			got.count     = m_tdata[O_CNT_LO +: COUNT_W];
			got.group_end = m_tuser;
			got.batch_end = m_tlast;
			if (extents_due.size() == 0) begin
				report_mismatch($sformatf("extent with none due: group %0h offset %0h",
					got.group, got.offset));
			end else begin
				want = extents_due.pop_front();
				if (got.group != want.group)
					report_mismatch($sformatf("group %0h, want %0h", got.group, want.group));
				if (got.offset != want.offset)
					report_mismatch($sformatf("offset %0h, want %0h", got.offset, want.offset));
				if (got.length != want.length)
					report_mismatch($sformatf("length %0h, want %0h", got.length, want.length));
				if (got.group_end != want.group_end)
					report_mismatch($sformatf("group end %0b, want %0b",
						got.group_end, want.group_end));
				if (got.batch_end != want.batch_end)
					report_mismatch($sformatf("batch end %0b, want %0b",
						got.batch_end, want.batch_end));
				if (got.count != want.count)
					report_mismatch($sformatf("extent count %0d, want %0d",
						got.count, want.count));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("read_extent_coalescer verification failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		req_t r;
		int   want_idx;
		int   sent;
		pend_valid    = 1'b0;
		pend_group    = '0;
		pend_off      = '0;
		pend_len      = '0;
		batch_extents = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		want_idx = 0;
		for (int i = 0; i < DIR_ROWS; i++) begin
			offer_request(dir_req[i]);
			if (dir_known[i] < 0) begin
				expect_predicted(dir_req[i]);
			end else begin
				coalesce_request(dir_req[i]);
				for (int k = 0; k < dir_known[i]; k++) begin
					extents_due.push_back(dir_want[want_idx]);
					want_idx++;
				end
			end
		end
		wait_all_taken();

		// random batches, with one long receiver hold partway through
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			send_random_batch($urandom_range(1, 12), sent);
			if (sent >= RANDOM_ITEMS / 2 && sent < RANDOM_ITEMS / 2 + 12) begin
				wait_all_taken();
				hold_req = 1'b1;
				paced_sender = 1'b0;
				// groups and offsets are random, so almost every request breaks the pending extent and yields a word
				for (int k = 0; k < HOLD_ITEMS; k++) begin
					r.group      = GROUP_W'($urandom);
					r.offset     = pick_offset();
					r.length     = pick_length();
					r.batch_last = (k == HOLD_ITEMS - 1);
					offer_request(r);
					expect_predicted(r);
				end
				paced_sender = 1'b1;
				wait_all_taken();
				sent += 12;
			end
		end
		wait_all_taken();

		// length overflow: 256 full-length requests, fill to the top exactly, then one more
		r.group  = 4'h7;
		r.offset = 40'h10;
		r.batch_last = 1'b0;
		for (int k = 0; k < 259; k++) begin
			if (k < 256) begin
				r.length = '1;
			end else if (k == 256) begin
				r.length = 24'hFF;
			end else begin
				r.length = 24'h1;
			end
			offer_request(r);
			expect_predicted(r);
			r.offset = r.offset + OFFSET_W'(r.length);
		end
		r.length     = 24'h1;
		r.batch_last = 1'b1;
		offer_request(r);
		expect_predicted(r);
		wait_all_taken();

		if (mismatch_count == 0) begin
			$display("read_extent_coalescer verification clean");
		end else begin
			$display("read_extent_coalescer verification failed");
		end
		$finish;
	end

endmodule
